// ----- rtl/core/shacbg_pkg.sv -----
// Shared types, constants and SHA-256 helper functions for the counter-mode bit generator.
`default_nettype none

package shacbg_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CTR_W    = 64;
    localparam int unsigned KEY_W    = 256;
    localparam int unsigned HELD_W   = 6;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [HELD_W-1:0] MAX_DRAW = 6'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67 = 3'd3;

    localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LEN_WORD = 32'h0000_0200;

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DRAW = 4'b0010,
        ST_HASH = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CTR_W-1:0] counter;
    } t_hash_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] word;
    } t_hash_rsp;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/shacbg_compress.sv -----
// Iterative SHA-256 compression of the counter block, one round per cycle.
`default_nettype none

module shacbg_compress (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [shacbg_pkg::KEY_W-1:0]  i_key,
    input  wire shacbg_pkg::t_hash_req         i_req,
    output shacbg_pkg::t_hash_rsp              o_rsp
);

    logic        r_busy;
    logic        r_fin;
    logic [5:0]  r_round;
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] r_w [16];

    logic [31:0] n_t1;
    logic [31:0] n_t2;
    logic [31:0] n_wnew;

    always_comb begin
        n_t1 = r_h + shacbg_pkg::big_sigma1(r_e) + ((r_e & r_f) ^ (~r_e & r_g))
             + shacbg_pkg::ROUND_K[r_round] + r_w[0];
        n_t2 = shacbg_pkg::big_sigma0(r_a) + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
        n_wnew = shacbg_pkg::small_sigma1(r_w[14]) + r_w[9]
               + shacbg_pkg::small_sigma0(r_w[1]) + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_key[255:224];
            r_b <= i_key[223:192];
            r_c <= i_key[191:160];
            r_d <= i_key[159:128];
            r_e <= i_key[127:96];
            r_f <= i_key[95:64];
            r_g <= i_key[63:32];
            r_h <= i_key[31:0];
            r_w[0] <= i_req.counter[63:32];
            r_w[1] <= i_req.counter[31:0];
            r_w[2] <= shacbg_pkg::PAD_WORD;
            for (int j = 3; j < 15; j++) begin
                r_w[j] <= '0;
            end
            r_w[15] <= shacbg_pkg::LEN_WORD;
        end else if (r_busy) begin
            r_h <= r_g;
            r_g <= r_f;
            r_f <= r_e;
            r_e <= r_d + n_t1;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_a;
            r_a <= n_t1 + n_t2;
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= n_wnew;
        end
    end

    assign o_rsp.done = r_fin;
    assign o_rsp.word = i_key[255:224] + r_a;

endmodule

`default_nettype wire

// ----- rtl/core/sha256_counter_bit_generator_core.sv -----
// Top level of the SHA-256 counter-mode random bit generator.
`default_nettype none

// Takes one transaction at a time: a flush or a draw of 0 to 32 bits (counts above
// 32 act as 32). A flush or a zero count goes from acceptance straight to the result
// register. A draw shifts bits from the buffer into the result one at a time; each
// time the buffer runs empty while bits are still owed, one refill runs the 64 rounds
// of the SHA-256 round unit between its load of the key and counter and its finish.
// At most one refill happens per draw. The result register holds its value until
// taken and the input is not ready meanwhile. Writing any key register clears the
// block counter.
module sha256_counter_bit_generator_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [shacbg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [63:0]                         i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_kind,
    input  wire logic [5:0]                          i_bit_count,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [31:0]                              o_drawn_bits
);

    shacbg_pkg::t_state    r_state;
    logic [63:0]           r_key01, r_key23, r_key45, r_key67;
    logic [63:0]           r_counter;
    logic [31:0]           r_buffer;
    logic [5:0]            r_held;
    logic [5:0]            r_cnt;
    logic [31:0]           r_result;

    shacbg_pkg::t_hash_req s_req;
    shacbg_pkg::t_hash_rsp s_rsp;
    logic                  s_in_acc;

    assign s_in_acc = i_valid && o_ready;
    assign o_ready  = (r_state == shacbg_pkg::ST_IDLE);
    assign o_valid  = (r_state == shacbg_pkg::ST_OUT);
    assign o_drawn_bits = r_result;

    assign s_req.start   = (r_state == shacbg_pkg::ST_DRAW) && (r_held == 6'd0);
    assign s_req.counter = r_counter;

    shacbg_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   ({r_key01, r_key23, r_key45, r_key67}),
        .i_req   (s_req),
        .o_rsp   (s_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key01 <= '0;
            r_key23 <= '0;
            r_key45 <= '0;
            r_key67 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                shacbg_pkg::CFG_KEY_01: r_key01 <= i_cfg_data;
                shacbg_pkg::CFG_KEY_23: r_key23 <= i_cfg_data;
                shacbg_pkg::CFG_KEY_45: r_key45 <= i_cfg_data;
                shacbg_pkg::CFG_KEY_67: r_key67 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= shacbg_pkg::ST_IDLE;
            r_counter <= '0;
            r_buffer  <= '0;
            r_held    <= '0;
            r_cnt     <= '0;
            r_result  <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index <= shacbg_pkg::CFG_KEY_67)) begin
                r_counter <= '0;
            end
            unique case (r_state)
                shacbg_pkg::ST_IDLE: begin
                    if (s_in_acc) begin
                        r_result <= '0;
                        if (i_kind) begin
                            r_buffer <= '0;
                            r_held   <= '0;
                            r_state  <= shacbg_pkg::ST_OUT;
                        end else if (i_bit_count == 6'd0) begin
                            r_state <= shacbg_pkg::ST_OUT;
                        end else begin
                            r_cnt   <= (i_bit_count > shacbg_pkg::MAX_DRAW) ?
                                       shacbg_pkg::MAX_DRAW : i_bit_count;
                            r_state <= shacbg_pkg::ST_DRAW;
                        end
                    end
                end
                shacbg_pkg::ST_DRAW: begin
                    if (r_held == 6'd0) begin
                        r_state <= shacbg_pkg::ST_HASH;
                    end else begin
                        r_result <= {r_result[30:0], r_buffer[0]};
                        r_buffer <= {1'b0, r_buffer[31:1]};
                        r_held   <= r_held - 6'd1;
                        r_cnt    <= r_cnt - 6'd1;
                        if (r_cnt == 6'd1) begin
                            r_state <= shacbg_pkg::ST_OUT;
                        end
                    end
                end
                shacbg_pkg::ST_HASH: begin
                    if (s_rsp.done) begin
                        r_buffer  <= s_rsp.word;
                        r_held    <= shacbg_pkg::MAX_DRAW;
                        r_counter <= r_counter + 64'd1;
                        r_state   <= shacbg_pkg::ST_DRAW;
                    end
                end
                shacbg_pkg::ST_OUT: begin
                    if (i_ready) begin
                        r_state <= shacbg_pkg::ST_IDLE;
                    end
                end
                default: r_state <= shacbg_pkg::ST_IDLE;
            endcase
        end
    end

    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready and valid high together");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= shacbg_pkg::MAX_DRAW)
        else $error("bit buffer count out of range");

    a_refill_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shacbg_pkg::ST_HASH) && s_rsp.done |=>
            (r_held == shacbg_pkg::MAX_DRAW) && (r_state == shacbg_pkg::ST_DRAW))
        else $error("refill did not fill the buffer");

    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc && i_kind |=> (r_held == 6'd0) && o_valid && (o_drawn_bits == 32'd0))
        else $error("flush did not empty the buffer");

endmodule

`default_nettype wire
